// File: src/assert_macros.svh
// Assertion macros shared by the extractor RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define ASSERT_IMPL(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Clocked assertion on the house clock and reset names.
`define ASSERT_CLK(label, prop, msg) `ASSERT_IMPL(label, clk, arst_n, prop, msg)

`endif

// File: src/drie_pkg.sv
// Types and constants of the delimited record integer extractor.
package drie_pkg;

	// Byte codes
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SEPARATOR    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COLUMN   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_COLUMN = 2'd2;

	// Configuration widths and reset values
	localparam int unsigned CFG_DATA_BITS = 8;
	localparam int unsigned COLUMN_BITS   = 4;
	localparam logic [7:0] SEPARATOR_RESET = 8'h7C;
	localparam logic [COLUMN_BITS-1:0] KEY_COLUMN_RESET   = 4'd0;
	localparam logic [COLUMN_BITS-1:0] VALUE_COLUMN_RESET = 4'd1;

	// Stream widths
	localparam int unsigned OUT_NUMBER_BITS = 32;
	localparam int unsigned IN_TDATA_BITS   = 8;
	localparam int unsigned OUT_TDATA_BITS  = 72;

	// Field parser phase
	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_MINUS  = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// Per-column parser control
	typedef struct packed {
		logic step;   // apply the current byte to this column
		logic clear;  // record ends: return to start of field
	} drie_ctl_t;

	// Per-column parser result, reflecting the current byte
	typedef struct packed {
		logic                       overflow;
		logic [OUT_NUMBER_BITS-1:0] number;
	} drie_num_t;

	// One result item, packed lowest field in the lowest bits
	typedef struct packed {
		logic                       value_overflow;
		logic                       key_overflow;
		logic [OUT_NUMBER_BITS-1:0] value_number;
		logic [OUT_NUMBER_BITS-1:0] key_number;
	} drie_result_t;

endpackage

// File: src/drie_num_parser.sv
// Signed decimal field parser for one selected column.
`include "assert_macros.svh"

module drie_num_parser
	import drie_pkg::*;
#(
	parameter int NUMBER_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  drie_ctl_t  ctl,
	input  logic [7:0] data_byte,
	output drie_num_t  result
);

	localparam int AW = NUMBER_BITS;
	localparam int WW = NUMBER_BITS + 4;
	localparam int OW = (NUMBER_BITS > OUT_NUMBER_BITS) ? NUMBER_BITS : OUT_NUMBER_BITS;

	logic [AW-1:0] acc_q, acc_n;
	phase_t        phase_q, phase_n;
	logic          neg_q, neg_n;
	logic          big_q, big_n;

	logic          is_digit;
	logic          take_digit;
	logic [WW-1:0] limit_w;
	logic [WW-1:0] prod_w;
	logic          too_big;
	logic [OW-1:0] mag_w;
	logic [OW-1:0] signed_w;

	// Candidate magnitude and its range check
	always_comb begin
		is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
		limit_w  = ((WW'(1) << (AW - 1)) - WW'(1)) + WW'(neg_q);
		prod_w   = (WW'(acc_q) << 3) + (WW'(acc_q) << 1) + WW'(data_byte[3:0]);
		too_big  = prod_w > limit_w;
	end

	// Advance the field phase on a byte of this column
	always_comb begin
		acc_n      = acc_q;
		phase_n    = phase_q;
		neg_n      = neg_q;
		big_n      = big_q;
		take_digit = 1'b0;
		if (ctl.step) begin
			case (phase_q)
				PH_START: begin
					if (data_byte == CHAR_MINUS) begin
						phase_n = PH_MINUS;
						neg_n   = 1'b1;
					end else if (is_digit) begin
						take_digit = 1'b1;
					end else begin
						phase_n = PH_DONE;
					end
				end
				PH_MINUS, PH_DIGITS: begin
					if (is_digit) begin
						take_digit = 1'b1;
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
		if (take_digit) begin
			phase_n = PH_DIGITS;
			if (!big_q) begin
				if (too_big) begin
					big_n = 1'b1;
					acc_n = '0;
				end else begin
					acc_n = prod_w[AW-1:0];
				end
			end
		end
	end

	// Form the signed result from the updated state
	always_comb begin
		mag_w           = OW'(acc_n);
		signed_w        = neg_n ? (OW'(0) - mag_w) : mag_w;
		result.overflow = big_n;
		result.number   = big_n ? '0 : signed_w[OUT_NUMBER_BITS-1:0];
	end

	// Hold parser state, clear at record end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			big_q   <= 1'b0;
		end else if (ctl.clear) begin
			acc_q   <= '0;
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			big_q   <= 1'b0;
		end else begin
			acc_q   <= acc_n;
			phase_q <= phase_n;
			neg_q   <= neg_n;
			big_q   <= big_n;
		end
	end

	`ASSERT_CLK(a_big_zero_acc, big_q |-> (acc_q == '0), "overflowed field kept a magnitude")
	`ASSERT_CLK(a_start_clean, (phase_q == PH_START) |-> ((acc_q == '0) && !neg_q), "field start not clean")
	`ASSERT_CLK(a_clear_start, ctl.clear |=> (phase_q == PH_START), "record end did not restart field")

endmodule

// File: src/drie_out_buffer.sv
// Two-entry result buffer: output register plus skid register.
`include "assert_macros.svh"

module drie_out_buffer #(
	parameter int WIDTH = 66
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic             main_valid_q;
	logic [WIDTH-1:0] main_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             pop;

	assign pop       = main_valid_q && out_ready;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_data_q;

	// Control: advance the skid into the output register when it frees up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !main_valid_q) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (pop || !main_valid_q) begin
			if (skid_valid_q) begin
				main_data_q <= skid_data_q;
				if (push) begin
					skid_data_q <= push_data;
				end
			end else if (push) begin
				main_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	`ASSERT_CLK(a_skid_needs_main, skid_valid_q |-> main_valid_q, "skid item without output item")
	`ASSERT_CLK(a_no_push_when_full, skid_valid_q |-> !push, "item pushed into a full buffer")
	`ASSERT_CLK(a_stall_to_skid, (push && main_valid_q && !out_ready) |=> skid_valid_q, "stalled push lost")

endmodule

// File: src/delimited_record_int_extractor.sv
// Delimited record integer extractor: top level.
//
// Input stream (s_*): one text byte per item in s_tdata[7:0]; s_tlast marks
// the last byte of the whole data stream. Records end at a newline byte;
// fields are split by the configured separator byte.
// Output stream (m_*): one result item per record, issued for its newline
// byte or for the last byte of the stream when no newline ends it.
// Configuration (cfg_*): write separator, key column and value column only
// while the block is idle; a write takes effect at the next clock edge.
// Timing: the result item is registered into the output buffer when the ending byte
// is accepted. Throughput: one byte per cycle while s_tready is high; the digit
// accumulate (multiply by ten, add, range compare) is combinational.
// Stall: results queue in an output register plus a skid register; s_tready
// falls only while both hold a result, and rises once m_tready drains one.
// Reset (arst_n low): registers return to separator '|', key column 0, value
// column 1; the column counter and both field parsers restart; no result is
// pending after reset.
module delimited_record_int_extractor
	import drie_pkg::*;
#(
	parameter int MAX_COLUMNS = 16,
	parameter int NUMBER_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Input stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [7:0] data_byte
	input  logic                      s_tlast,   // final_byte
	// Output stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_TDATA_BITS-1:0] m_tdata,   // [31:0] key_number, [63:32] value_number,
	                                             // [64] key_overflow, [65] value_overflow
	// Configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

	localparam int CW   = $clog2(MAX_COLUMNS + 1);
	localparam int CMPW = (CW > COLUMN_BITS) ? CW : COLUMN_BITS;
	localparam int RW   = $bits(drie_result_t);

	logic [7:0]             separator_q;
	logic [COLUMN_BITS-1:0] key_column_q;
	logic [COLUMN_BITS-1:0] value_column_q;
	logic [CW-1:0]          column_q;

	logic         accept;
	logic         is_newline;
	logic         is_sep;
	logic         in_range;
	logic         emit;
	logic         buf_full;
	drie_ctl_t    key_ctl, value_ctl;
	drie_num_t    key_res, value_res;
	drie_result_t result;
	logic [RW-1:0] buf_out;

	assign s_tready = !buf_full;
	assign accept   = s_tvalid && s_tready;

	// Classify the byte and route it to the selected columns
	always_comb begin
		is_newline      = s_tdata == CHAR_NEWLINE;
		is_sep          = !is_newline && (s_tdata == separator_q);
		in_range        = column_q < CW'(MAX_COLUMNS);
		emit            = accept && (is_newline || s_tlast);
		key_ctl.step    = accept && !is_newline && !is_sep && in_range &&
		                  (CMPW'(column_q) == CMPW'(key_column_q));
		value_ctl.step  = accept && !is_newline && !is_sep && in_range &&
		                  (CMPW'(column_q) == CMPW'(value_column_q));
		key_ctl.clear   = emit;
		value_ctl.clear = emit;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q    <= SEPARATOR_RESET;
			key_column_q   <= KEY_COLUMN_RESET;
			value_column_q <= VALUE_COLUMN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEPARATOR:    separator_q    <= cfg_wdata;
				REG_KEY_COLUMN:   key_column_q   <= cfg_wdata[COLUMN_BITS-1:0];
				REG_VALUE_COLUMN: value_column_q <= cfg_wdata[COLUMN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Column counter: count separators, saturate, restart per record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (emit) begin
			column_q <= '0;
		end else if (accept && is_sep && in_range) begin
			column_q <= column_q + CW'(1);
		end
	end

	drie_num_parser #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_key_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (key_ctl),
		.data_byte (s_tdata[7:0]),
		.result    (key_res)
	);

	drie_num_parser #(
		.NUMBER_BITS(NUMBER_BITS)
	) u_value_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (value_ctl),
		.data_byte (s_tdata[7:0]),
		.result    (value_res)
	);

	// Assemble the result item
	always_comb begin
		result.key_number     = key_res.number;
		result.value_number   = value_res.number;
		result.key_overflow   = key_res.overflow;
		result.value_overflow = value_res.overflow;
	end

	drie_out_buffer #(
		.WIDTH(RW)
	) u_out_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_data (result),
		.full      (buf_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (buf_out)
	);

	assign m_tdata = {(OUT_TDATA_BITS - RW)'(0), buf_out};

endmodule
